>>> hw/rtl/mexp_pkg.sv
package mexp_pkg;

	localparam int DATA_W    = 32;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int CNT_W     = $clog2(DATA_W);
	localparam int CFG_IDX_W = 1;

	typedef logic [DATA_W-1:0] word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_EXPONENT = 1'b0;
	localparam cfg_idx_t REG_MODULUS  = 1'b1;

	typedef enum logic {
		MM_IDLE,
		MM_RED
	} mm_state_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SQR,
		ST_SQR_W,
		ST_MUL,
		ST_MUL_W
	} seq_state_t;

endpackage

>>> hw/rtl/mexp_modmul.sv
module mexp_modmul (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  mexp_pkg::word_t a,
	input  mexp_pkg::word_t b,
	input  mexp_pkg::word_t m,
	output logic            done,
	output mexp_pkg::word_t res
);
	import mexp_pkg::*;

	mm_state_t         state_q, state_d;
	word_t             rem_q, lo_q, res_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [PROD_W-1:0] prod;
	logic [DATA_W:0]   trial, diff;
	word_t             rem_next;
	logic              fits, last, load, step, mod_zero;

	// one 32x32 multiply, registered straight into the reduction registers
	assign prod     = PROD_W'(a) * PROD_W'(b);
	assign mod_zero = (m == '0);

	// restoring reduction, one product bit per cycle; high word is already below m
	assign trial    = {rem_q, lo_q[DATA_W-1]};
	assign diff     = trial - {1'b0, m};
	assign fits     = ~diff[DATA_W];
	assign rem_next = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
	assign last     = (cnt_q == CNT_W'(DATA_W - 1));

	always_comb begin
		state_d = state_q;
		load    = 1'b0;
		step    = 1'b0;
		case (state_q)
			MM_IDLE: begin
				if (go) begin
					load = 1'b1;
					if (!mod_zero)
						state_d = MM_RED;
				end
			end
			MM_RED: begin
				step = 1'b1;
				if (last)
					state_d = MM_IDLE;
			end
			default: state_d = MM_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (load && mod_zero) || (step && last);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= prod[PROD_W-1:DATA_W];
			lo_q  <= prod[DATA_W-1:0];
			cnt_q <= '0;
			// modulus zero: plain wrap to the word
			if (mod_zero)
				res_q <= prod[DATA_W-1:0];
		end else if (step) begin
			rem_q <= rem_next;
			lo_q  <= lo_q << 1;
			cnt_q <= cnt_q + CNT_W'(1);
			if (last)
				res_q <= rem_next;
		end
	end

	assign done = done_q;
	assign res  = res_q;

	a_rem_below_mod: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == MM_RED |-> rem_q < m)
		else $error("partial remainder not below modulus");

	a_go_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> state_q == MM_IDLE)
		else $error("operation issued while reduction in progress");

endmodule

>>> hw/rtl/modular_exponentiation_core.sv
// Channel   Signals                                 Transfer
// input     start, busy, base                       start && !busy at clk edge
// result    done, power_mod                         done high for one cycle
// config    cfg_wr_en, cfg_index, cfg_data          cfg_wr_en at clk edge
//
// Each square or multiply uses one shared multiplier plus a 32-step restoring
// reduction, skipped when the modulus is zero. Exponent zero answers in the next
// cycle. arst_n clears control and sets both registers to 1. No stall on results.
module modular_exponentiation_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mexp_pkg::word_t    base,
	output logic               done,
	output mexp_pkg::word_t    power_mod,
	input  logic               cfg_wr_en,
	input  mexp_pkg::cfg_idx_t cfg_index,
	input  mexp_pkg::word_t    cfg_data
);
	import mexp_pkg::*;

	seq_state_t       state_q, state_d;
	word_t            exponent_q, modulus_q;
	word_t            base_q, exp_q, mod_q, acc_q, pm_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic             accept, go, mul_sel, acc_ld, shift, fin, fin_one;
	logic             mm_done;
	word_t            mm_res, mm_b;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign mm_b   = mul_sel ? base_q : acc_q;

	mexp_modmul u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.a      (acc_q),
		.b      (mm_b),
		.m      (mod_q),
		.done   (mm_done),
		.res    (mm_res)
	);

	always_comb begin
		state_d = state_q;
		go      = 1'b0;
		mul_sel = 1'b0;
		acc_ld  = 1'b0;
		shift   = 1'b0;
		fin     = 1'b0;
		fin_one = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (exponent_q == '0)
						fin_one = 1'b1;
					else
						state_d = ST_SCAN;
				end
			end
			// skip leading zeros of the exponent
			ST_SCAN: begin
				if (exp_q[DATA_W-1])
					state_d = ST_SQR;
				else
					shift = 1'b1;
			end
			ST_SQR: begin
				go      = 1'b1;
				state_d = ST_SQR_W;
			end
			ST_SQR_W: begin
				if (mm_done) begin
					acc_ld = 1'b1;
					if (exp_q[DATA_W-1]) begin
						state_d = ST_MUL;
					end else if (cnt_q == '0) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						shift   = 1'b1;
						state_d = ST_SQR;
					end
				end
			end
			ST_MUL: begin
				go      = 1'b1;
				mul_sel = 1'b1;
				state_d = ST_MUL_W;
			end
			ST_MUL_W: begin
				if (mm_done) begin
					acc_ld = 1'b1;
					if (cnt_q == '0) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
					end else begin
						shift   = 1'b1;
						state_d = ST_SQR;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			done_q     <= 1'b0;
			exponent_q <= word_t'(1);
			modulus_q  <= word_t'(1);
		end else begin
			state_q <= state_d;
			done_q  <= fin || fin_one;
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_EXPONENT: exponent_q <= cfg_data;
					REG_MODULUS:  modulus_q  <= cfg_data;
					default:      ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			base_q <= base;
			exp_q  <= exponent_q;
			mod_q  <= modulus_q;
			cnt_q  <= CNT_W'(DATA_W - 1);
			acc_q  <= word_t'(1);
		end else begin
			if (shift) begin
				exp_q <= exp_q << 1;
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (acc_ld)
				acc_q <= mm_res;
		end
		if (fin)
			pm_q <= mm_res;
		else if (fin_one)
			pm_q <= word_t'(1);
	end

	assign done      = done_q;
	assign power_mod = pm_q;

	a_mm_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_SQR_W || state_q == ST_MUL_W))
		else $error("modmul result arrived outside a wait state");

	a_acc_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL && mod_q != '0) |-> acc_q < mod_q)
		else $error("accumulator not reduced before multiply");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still working");

endmodule
